FILE: rtl/core/sgi_pkg.sv
`default_nettype none
package sgi_pkg;

   // queue between the front and back parts
   localparam int SGI_QDEPTH = 4;
   localparam int SGI_QAW    = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } sgi_qstat_type;

endpackage
`default_nettype wire

FILE: rtl/core/sgi_front.sv
`default_nettype none
module sgi_front import sgi_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [COORD_WIDTH-1:0]        req_a_start_x,
   input  wire logic [COORD_WIDTH-1:0]        req_a_start_y,
   input  wire logic [COORD_WIDTH-1:0]        req_a_end_x,
   input  wire logic [COORD_WIDTH-1:0]        req_a_end_y,
   input  wire logic [COORD_WIDTH-1:0]        req_b_start_x,
   input  wire logic [COORD_WIDTH-1:0]        req_b_start_y,
   input  wire logic [COORD_WIDTH-1:0]        req_b_end_x,
   input  wire logic [COORD_WIDTH-1:0]        req_b_end_y,
   input  wire sgi_qstat_type                 qstat,
   output logic                               push,
   output logic [10*COORD_WIDTH+4*COORD_WIDTH+8:0] push_data
);
   localparam int W    = COORD_WIDTH;
   localparam int DIFW = W + 1;
   localparam int PW   = 2 * DIFW;
   localparam int DW   = PW + 1;

   logic                   adv;
   logic                   v1_ff, v2_ff;
   logic [8*W-1:0]         pts1_ff, pts2_ff;
   logic signed [DIFW-1:0] dax1_ff, day1_ff, dbx1_ff, dby1_ff, ex1_ff, ey1_ff;
   logic signed [DIFW-1:0] dax2_ff, day2_ff;
   logic signed [PW-1:0]   pab_ff, pba_ff, peb_ff, pfb_ff;
   logic signed [DW-1:0]   den, tn;

   assign adv       = !(v2_ff && qstat.full);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   // stage 1: differences
   always_ff @(posedge clock) begin
      if (adv) begin
         pts1_ff <= {req_a_start_x, req_a_start_y, req_a_end_x, req_a_end_y,
                     req_b_start_x, req_b_start_y, req_b_end_x, req_b_end_y};
         dax1_ff <= DIFW'($signed(req_a_end_x)) - DIFW'($signed(req_a_start_x));
         day1_ff <= DIFW'($signed(req_a_end_y)) - DIFW'($signed(req_a_start_y));
         dbx1_ff <= DIFW'($signed(req_b_end_x)) - DIFW'($signed(req_b_start_x));
         dby1_ff <= DIFW'($signed(req_b_end_y)) - DIFW'($signed(req_b_start_y));
         ex1_ff  <= DIFW'($signed(req_b_start_x)) - DIFW'($signed(req_a_start_x));
         ey1_ff  <= DIFW'($signed(req_b_start_y)) - DIFW'($signed(req_a_start_y));
      end
   end

   // stage 2: cross-product terms
   always_ff @(posedge clock) begin
      if (adv) begin
         pts2_ff <= pts1_ff;
         dax2_ff <= dax1_ff;
         day2_ff <= day1_ff;
         pab_ff  <= PW'(dax1_ff) * PW'(dby1_ff);
         pba_ff  <= PW'(day1_ff) * PW'(dbx1_ff);
         peb_ff  <= PW'(ex1_ff) * PW'(dby1_ff);
         pfb_ff  <= PW'(ey1_ff) * PW'(dbx1_ff);
      end
   end

   assign den       = DW'(pab_ff) - DW'(pba_ff);
   assign tn        = DW'(peb_ff) - DW'(pfb_ff);
   assign push      = v2_ff && !qstat.full;
   assign push_data = {pts2_ff, dax2_ff, day2_ff, den, tn, (den == '0)};
endmodule
`default_nettype wire

FILE: rtl/core/sgi_queue.sv
`default_nettype none
module sgi_queue import sgi_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output sgi_qstat_type         qstat
);
   logic [WIDTH-1:0]   entry_ff [SGI_QDEPTH];
   logic [SGI_QAW-1:0] wr_ff, rd_ff;
   logic [SGI_QAW:0]   count_ff;

   assign qstat.full  = (count_ff == (SGI_QAW+1)'(SGI_QDEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_data    = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

FILE: rtl/core/sgi_back.sv
`default_nettype none
module sgi_back import sgi_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sgi_qstat_type                      qstat,
   input  wire logic [10*COORD_WIDTH+4*COORD_WIDTH+8:0] pop_data,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_hit,
   output logic                                    rsp_lines_parallel,
   output logic [COORD_WIDTH-1:0]                  rsp_meet_x,
   output logic [COORD_WIDTH-1:0]                  rsp_meet_y
);
   localparam int W    = COORD_WIDTH;
   localparam int DIFW = W + 1;
   localparam int DW   = 2 * DIFW + 1;
   localparam int NW   = DIFW + DW + 1;
   localparam int NPW  = NW + 1;
   localparam int RW   = DW + W;

   logic adv;

   // queue head fields
   logic [8*W-1:0]         q_pts;
   logic signed [DIFW-1:0] q_dax, q_day;
   logic signed [DW-1:0]   q_den, q_tn;
   logic                   q_par;

   assign {q_pts, q_dax, q_day, q_den, q_tn, q_par} = pop_data;

   assign adv = !(rsp_valid && rsp_stall);
   assign pop = adv && !qstat.empty;

   // stage 1: make the denominator non-negative
   logic                   v1_ff, par1_ff;
   logic [8*W-1:0]         pts1_ff;
   logic signed [DIFW-1:0] dax1_ff, day1_ff;
   logic signed [DW-1:0]   den1_ff, tn1_ff;

   // stage 2: products
   logic                   v2_ff, par2_ff;
   logic [8*W-1:0]         pts2_ff;
   logic signed [DW-1:0]   den2_ff;
   logic signed [NW-1:0]   mx1_ff, mx2_ff, my1_ff, my2_ff;

   // stage 3: numerators
   logic                   v3_ff, par3_ff;
   logic [8*W-1:0]         pts3_ff;
   logic signed [DW-1:0]   den3_ff;
   logic signed [NW-1:0]   nx3_ff, ny3_ff;

   logic signed [NPW-1:0]  npx, npy, dlo, dhi;

   // divider chain, index 0 fed by the range check
   logic           dv_ff   [W+1];
   logic           dpar_ff [W+1];
   logic [8*W-1:0] dpts_ff [W+1];
   logic [DW-1:0]  dden_ff [W+1];
   logic [3:0]     drng_ff [W+1];
   logic [RW-1:0]  rx_ff   [W+1];
   logic [RW-1:0]  ry_ff   [W+1];
   logic [W-1:0]   qx_ff   [W+1];
   logic [W-1:0]   qy_ff   [W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         dv_ff[0]  <= 1'b0;
      end else if (adv) begin
         v1_ff     <= !qstat.empty;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         dv_ff[0]  <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pts1_ff <= q_pts;
         par1_ff <= q_par;
         dax1_ff <= q_dax;
         day1_ff <= q_day;
         den1_ff <= q_den[DW-1] ? -q_den : q_den;
         tn1_ff  <= q_den[DW-1] ? -q_tn : q_tn;

         pts2_ff <= pts1_ff;
         par2_ff <= par1_ff;
         den2_ff <= den1_ff;
         mx1_ff  <= NW'($signed(pts1_ff[7*W +: W])) * NW'(den1_ff);
         mx2_ff  <= NW'(dax1_ff) * NW'(tn1_ff);
         my1_ff  <= NW'($signed(pts1_ff[6*W +: W])) * NW'(den1_ff);
         my2_ff  <= NW'(day1_ff) * NW'(tn1_ff);

         pts3_ff <= pts2_ff;
         par3_ff <= par2_ff;
         den3_ff <= den2_ff;
         nx3_ff  <= mx1_ff + mx2_ff;
         ny3_ff  <= my1_ff + my2_ff;
      end
   end

   // offset the numerator by half the output range; quotient then lands in [0, 2^W)
   assign dlo = NPW'(den3_ff) <<< (W - 1);
   assign dhi = NPW'(den3_ff) <<< W;
   assign npx = NPW'(nx3_ff) + dlo;
   assign npy = NPW'(ny3_ff) + dlo;

   always_ff @(posedge clock) begin
      if (adv) begin
         dpts_ff[0] <= pts3_ff;
         dpar_ff[0] <= par3_ff;
         dden_ff[0] <= den3_ff[DW-1:0];
         // {x high, x low, y high, y low}
         drng_ff[0] <= {(npx >= dhi), npx[NPW-1], (npy >= dhi), npy[NPW-1]};
         rx_ff[0]   <= npx[RW-1:0];
         ry_ff[0]   <= npy[RW-1:0];
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
      end
   end

   // restoring division, one quotient bit a stage
   for (genvar k = 0; k < W; k++) begin : g_div
      localparam int BIT = W - 1 - k;
      logic [RW-1:0] dsh;
      logic          gex, gey;

      assign dsh = RW'(dden_ff[k]) << BIT;
      assign gex = rx_ff[k] >= dsh;
      assign gey = ry_ff[k] >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dpts_ff[k+1] <= dpts_ff[k];
            dpar_ff[k+1] <= dpar_ff[k];
            dden_ff[k+1] <= dden_ff[k];
            drng_ff[k+1] <= drng_ff[k];
            rx_ff[k+1]   <= gex ? rx_ff[k] - dsh : rx_ff[k];
            ry_ff[k+1]   <= gey ? ry_ff[k] - dsh : ry_ff[k];
            // bit BIT is still clear on the way in
            qx_ff[k+1]   <= qx_ff[k] | (W'(gex) << BIT);
            qy_ff[k+1]   <= qy_ff[k] | (W'(gey) << BIT);
         end
      end
   end

   // final: undo the offset, saturate, bounding-box test
   logic signed [W-1:0] px, py, smax, smin;
   logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   logic                inrange, hit_in;
   logic [W-1:0]        mx_in, my_in;

   logic                valid_ff, hit_ff, par_ff;
   logic [W-1:0]        mx_ff, my_ff;

   assign smax = {1'b0, {(W-1){1'b1}}};
   assign smin = {1'b1, {(W-1){1'b0}}};
   assign px   = {~qx_ff[W][W-1], qx_ff[W][W-2:0]};
   assign py   = {~qy_ff[W][W-1], qy_ff[W][W-2:0]};
   assign x1   = dpts_ff[W][7*W +: W];
   assign y1   = dpts_ff[W][6*W +: W];
   assign x2   = dpts_ff[W][5*W +: W];
   assign y2   = dpts_ff[W][4*W +: W];
   assign x3   = dpts_ff[W][3*W +: W];
   assign y3   = dpts_ff[W][2*W +: W];
   assign x4   = dpts_ff[W][1*W +: W];
   assign y4   = dpts_ff[W][0 +: W];

   assign inrange = (drng_ff[W] == 4'b0000);

   always_comb begin
      hit_in = !dpar_ff[W] && inrange &&
               ((px >= x1 && px <= x2) || (px >= x2 && px <= x1)) &&
               ((py >= y1 && py <= y2) || (py >= y2 && py <= y1)) &&
               ((px >= x3 && px <= x4) || (px >= x4 && px <= x3)) &&
               ((py >= y3 && py <= y4) || (py >= y4 && py <= y3));
      if (dpar_ff[W])         mx_in = '0;
      else if (drng_ff[W][3]) mx_in = smax;
      else if (drng_ff[W][2]) mx_in = smin;
      else                    mx_in = px;
      if (dpar_ff[W])         my_in = '0;
      else if (drng_ff[W][1]) my_in = smax;
      else if (drng_ff[W][0]) my_in = smin;
      else                    my_in = py;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= dv_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
         par_ff <= dpar_ff[W];
         mx_ff  <= mx_in;
         my_ff  <= my_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_lines_parallel = par_ff;
   assign rsp_meet_x         = mx_ff;
   assign rsp_meet_y         = my_ff;
endmodule
`default_nettype wire

FILE: rtl/core/segment_intersection_2d_top.sv
// Path: front registers, queue, back registers, divider chain, output register.
// Throughput: one segment pair per cycle when no stall holds it, with a pipelined divider chain.
// Reset: synchronous, active high; clears all valid bits and the queue pointers.
// No clearing pass; the block takes a transfer in the first cycle after reset.
`default_nettype none
module segment_intersection_2d_top import sgi_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COORD_WIDTH-1:0] req_a_start_x,
   input  wire logic [COORD_WIDTH-1:0] req_a_start_y,
   input  wire logic [COORD_WIDTH-1:0] req_a_end_x,
   input  wire logic [COORD_WIDTH-1:0] req_a_end_y,
   input  wire logic [COORD_WIDTH-1:0] req_b_start_x,
   input  wire logic [COORD_WIDTH-1:0] req_b_start_y,
   input  wire logic [COORD_WIDTH-1:0] req_b_end_x,
   input  wire logic [COORD_WIDTH-1:0] req_b_end_y,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_hit,
   output logic                        rsp_lines_parallel,
   output logic [COORD_WIDTH-1:0]      rsp_meet_x,
   output logic [COORD_WIDTH-1:0]      rsp_meet_y
);
   // Queue entry: eight points, two A deltas, signed denominator and numerator, parallel flag
   localparam int QW = 14 * COORD_WIDTH + 9;

   sgi_qstat_type   qstat;
   logic            push, pop;
   logic [QW-1:0]   push_data, pop_data;

   // Front: registers the transfer, forms the differences and the two cross products,
   // flags parallel lines (zero denominator).
   sgi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_a_start_x, .req_a_start_y, .req_a_end_x, .req_a_end_y,
      .req_b_start_x, .req_b_start_y, .req_b_end_x, .req_b_end_y,
      .qstat, .push, .push_data
   );

   // Short queue decouples the two halves so each can stall on its own.
   sgi_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset,
      .push, .push_data,
      .pop, .pop_data,
      .qstat
   );

   // Back: sign normalise, numerator products, range check, floored division
   // one bit per stage, then saturation and the bounding-box test into the
   // output register.
   sgi_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock, .reset,
      .qstat, .pop_data, .pop,
      .rsp_valid, .rsp_stall,
      .rsp_hit, .rsp_lines_parallel, .rsp_meet_x, .rsp_meet_y
   );
endmodule
`default_nettype wire

FILE: rtl/core/sgi_checker.sv
`default_nettype none
module sgi_checker #(
   parameter int COORD_WIDTH = 16
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic                   rsp_hit,
   input wire logic                   rsp_lines_parallel,
   input wire logic [COORD_WIDTH-1:0] rsp_meet_x,
   input wire logic [COORD_WIDTH-1:0] rsp_meet_y
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lines_parallel |-> !rsp_hit && rsp_meet_x == '0 && rsp_meet_y == '0)
      else $error("parallel result not zeroed");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_meet_x) && $stable(rsp_meet_y)
                                 && $stable(rsp_hit))
      else $error("stalled result changed");
endmodule

bind segment_intersection_2d_top sgi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sgi_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_hit, .rsp_lines_parallel,
   .rsp_meet_x, .rsp_meet_y
);
`default_nettype wire
